// ===== sv/emboss_shading_filter_assert.svh =====
// Assertion macros used by the esf_ctrl RTL module
`ifndef EMBOSS_SHADING_FILTER_ASSERT_SVH
`define EMBOSS_SHADING_FILTER_ASSERT_SVH
`ifndef SYNTH
`define ESF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esf assertion failed");
`define ESF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esf assertion failed");
`else
`define ESF_ASSERT_IMPL(name, ante, cons)
`define ESF_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== sv/esf_pkg.sv =====
`timescale 1ns / 1ps
package esf_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 28;
    localparam int SAMPLE_W = 10;
    localparam int GRAD_W   = 13;
    localparam int PROD_W   = 30;
    localparam int SQR_W    = 26;
    localparam int DOT_W    = 33;
    localparam int SUM_W    = 26;
    localparam int DSQ_W    = 62;
    localparam int ACC_W    = 48;
    localparam int SHADE_W  = 8;

    typedef enum logic [CFG_IW-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COLOR_MODE   = 3'd2,
        REG_LIGHT_X      = 3'd3,
        REG_LIGHT_Y      = 3'd4,
        REG_LIGHT_DOT_Z  = 3'd5,
        REG_NORMAL_Z_SQ  = 3'd6,
        REG_BACKGROUND   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [11:0]        image_width;
        logic [11:0]        image_height;
        logic               color_mode;
        logic signed [16:0] light_x;
        logic signed [16:0] light_y;
        logic signed [27:0] light_dot_z;
        logic [21:0]        normal_z_sq;
        logic signed [8:0]  background;
    } cfg_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } req_t;

    typedef struct packed {
        logic [7:0] shade;
        logic       frame_end;
    } res_t;

    typedef struct packed {
        logic col_zero;
        logic col_one;
        logic clamp_top;
        logic clamp_bot;
        logic frame_end;
    } slot_t;

    typedef struct packed {
        logic       load_item;
        logic       mem_read;
        logic       slot_load;
        logic       mul1;
        logic       mul2;
        logic       square;
        logic       search_step;
        logic       out_load;
        logic [2:0] bit_idx;
        slot_t      slot;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/esf_dp.sv =====
`timescale 1ns / 1ps
module esf_dp #(
    parameter int MAX_WIDTH = esf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  esf_pkg::cfg_t                cfg,
    input  esf_pkg::req_t                req_data,
    input  esf_pkg::cmd_t                cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    output esf_pkg::stat_t               stat,
    output logic                         res_valid,
    input  logic                         res_stall,
    output esf_pkg::res_t                res_data
);

    localparam int SW = esf_pkg::SAMPLE_W;

    logic [SW-1:0] upper_mem [MAX_WIDTH];
    logic [SW-1:0] middle_mem [MAX_WIDTH];

    logic [SW-1:0] sample_reg;
    logic [SW-1:0] top_reg;
    logic [SW-1:0] mid_reg;
    logic [SW-1:0] win_reg [9];
    logic [SW-1:0] win_next [9];
    logic [SW-1:0] shifted [9];
    logic [SW-1:0] src [9];
    logic [SW-1:0] rowsel [3][3];
    logic [SW-1:0] gl [3];
    logic [SW-1:0] gm [3];
    logic [SW-1:0] gr [3];
    logic [11:0]   sum_l;
    logic [11:0]   sum_r;
    logic [11:0]   sum_t;
    logic [11:0]   sum_b;

    logic signed [esf_pkg::GRAD_W-1:0] dx_reg, dx_next;
    logic signed [esf_pkg::GRAD_W-1:0] dy_reg, dy_next;
    logic signed [esf_pkg::PROD_W-1:0] px_reg, py_reg;
    logic [esf_pkg::SQR_W-1:0]         sqx_reg, sqy_reg;
    logic                              zero_reg;
    logic signed [esf_pkg::DOT_W-1:0]  dot_reg;
    logic [esf_pkg::SUM_W-1:0]         s_reg;
    logic [esf_pkg::DSQ_W-1:0]         dsq_reg;
    logic                              neg_reg;
    logic [esf_pkg::ACC_W-1:0]         acc_a_reg;
    logic [esf_pkg::ACC_W-1:0]         acc_b_reg;
    logic [7:0]                        q_reg;
    logic [esf_pkg::ACC_W-1:0]         dlim;
    logic [esf_pkg::ACC_W-1:0]         trial;
    logic [esf_pkg::ACC_W-1:0]         b_add;
    logic [3:0]                        sh_b;
    logic [3:0]                        sh_s;
    logic [SW-1:0]                     sample_next;

    logic          res_valid_reg;
    esf_pkg::res_t res_data_reg;
    logic [7:0]    shade_val;
    logic [7:0]    bg_val;

    always_comb
    begin
        if (req_data.req_type)
        begin
            sample_next = '0;
        end
        else if (cfg.color_mode)
        begin
            sample_next = SW'(req_data.chan0) + SW'(req_data.chan1) + SW'(req_data.chan2);
        end
        else
        begin
            sample_next = SW'(req_data.chan0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            shifted[k*3]     = win_reg[k*3+1];
            shifted[k*3+1]   = win_reg[k*3+2];
        end
        shifted[2] = top_reg;
        shifted[5] = mid_reg;
        shifted[8] = sample_reg;
        for (int k = 0; k < 9; k++)
        begin
            src[k]      = cmd.slot.col_zero ? win_reg[k] : shifted[k];
            win_next[k] = shifted[k];
        end
        for (int c = 0; c < 3; c++)
        begin
            rowsel[0][c] = cmd.slot.clamp_top ? src[3+c] : src[c];
            rowsel[1][c] = src[3+c];
            rowsel[2][c] = cmd.slot.clamp_bot ? src[3+c] : src[6+c];
        end
        for (int r = 0; r < 3; r++)
        begin
            gl[r] = (cmd.slot.col_zero || cmd.slot.col_one) ? rowsel[r][1] : rowsel[r][0];
            gm[r] = cmd.slot.col_zero ? rowsel[r][2] : rowsel[r][1];
            gr[r] = rowsel[r][2];
        end
        sum_l = 12'(gl[0]) + 12'(gl[1]) + 12'(gl[2]);
        sum_r = 12'(gr[0]) + 12'(gr[1]) + 12'(gr[2]);
        sum_t = 12'(gl[0]) + 12'(gm[0]) + 12'(gr[0]);
        sum_b = 12'(gl[2]) + 12'(gm[2]) + 12'(gr[2]);
        dx_next = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        dy_next = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end

    always_comb
    begin
        dlim  = esf_pkg::ACC_W'(dsq_reg[esf_pkg::DSQ_W-1:16]);
        sh_b  = 4'(cmd.bit_idx) + 4'd1;
        sh_s  = {cmd.bit_idx, 1'b0};
        trial = acc_a_reg + (acc_b_reg << sh_b) + (esf_pkg::ACC_W'(s_reg) << sh_s);
        b_add = esf_pkg::ACC_W'(s_reg) << cmd.bit_idx;
        bg_val = cfg.background[8] ? 8'd0 : cfg.background[7:0];
        if (zero_reg)
        begin
            shade_val = bg_val;
        end
        else if (neg_reg)
        begin
            shade_val = 8'd0;
        end
        else
        begin
            shade_val = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            top_reg <= upper_mem[addr];
            mid_reg <= middle_mem[addr];
        end
        if (cmd.slot_load)
        begin
            upper_mem[addr]  <= mid_reg;
            middle_mem[addr] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sample_reg <= sample_next;
        end
        if (cmd.slot_load)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.mul1)
        begin
            px_reg   <= dx_reg * cfg.light_x;
            py_reg   <= dy_reg * cfg.light_y;
            sqx_reg  <= esf_pkg::SQR_W'(dx_reg * dx_reg);
            sqy_reg  <= esf_pkg::SQR_W'(dy_reg * dy_reg);
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
        end
        if (cmd.mul2)
        begin
            dot_reg <= esf_pkg::DOT_W'(px_reg) + esf_pkg::DOT_W'(py_reg)
                     + esf_pkg::DOT_W'(cfg.light_dot_z);
            s_reg   <= sqx_reg + sqy_reg + esf_pkg::SUM_W'(cfg.normal_z_sq);
        end
        if (cmd.square)
        begin
            dsq_reg   <= esf_pkg::DSQ_W'(dot_reg[30:0]) * esf_pkg::DSQ_W'(dot_reg[30:0]);
            neg_reg   <= dot_reg[esf_pkg::DOT_W-1];
            acc_a_reg <= '0;
            acc_b_reg <= '0;
            q_reg     <= '0;
        end
        if (cmd.search_step && (trial <= dlim))
        begin
            acc_a_reg            <= trial;
            acc_b_reg            <= acc_b_reg + b_add;
            q_reg[cmd.bit_idx]   <= 1'b1;
        end
        if (cmd.out_load)
        begin
            res_data_reg.shade     <= shade_val;
            res_data_reg.frame_end <= cmd.slot.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.slot_load)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
            if (cmd.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = res_valid_reg && res_stall;
    assign res_valid     = res_valid_reg;
    assign res_data      = res_data_reg;

endmodule

// ===== sv/esf_ctrl.sv =====
`timescale 1ns / 1ps
`include "emboss_shading_filter_assert.svh"
module esf_ctrl #(
    parameter int MAX_WIDTH = esf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  esf_pkg::cfg_t                cfg,
    input  logic                         req_valid,
    input  logic                         req_type,
    output logic                         req_stall,
    output esf_pkg::cmd_t                cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  esf_pkg::stat_t               stat
);

    localparam int NW = $clog2(MAX_WIDTH + 2);
    localparam int XW = (NW > 12) ? NW : 12;
    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_NORM   = 10'b0000000010,
        ST_DECODE = 10'b0000000100,
        ST_READ   = 10'b0000001000,
        ST_LOAD   = 10'b0000010000,
        ST_MUL1   = 10'b0000100000,
        ST_MUL2   = 10'b0001000000,
        ST_SQUARE = 10'b0010000000,
        ST_SEARCH = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [NW-1:0]  col_reg, col_next;
    logic [11:0]    row_reg, row_next;
    logic [NW-1:0]  pend_reg, pend_next;
    logic           drain_reg, drain_next;
    logic           emit_reg, emit_next;
    esf_pkg::slot_t slot_reg, slot_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [2:0]     bit_reg, bit_next;

    logic [XW-1:0]  wx;
    logic [NW-1:0]  w_eff;
    logic [NW-1:0]  w_p1;
    logic [11:0]    h_eff;
    logic [12:0]    row_inc;
    logic [12:0]    row_t;
    logic [NW-1:0]  col_inc;
    logic [NW-1:0]  dc;
    logic [NW-1:0]  p0;
    logic           at_start;

    always_comb
    begin
        wx = XW'(cfg.image_width);
        if (wx < XW'(3))
        begin
            w_eff = NW'(3);
        end
        else if (wx > XW'(MAX_WIDTH))
        begin
            w_eff = NW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = wx[NW-1:0];
        end
        w_p1  = w_eff + NW'(1);
        h_eff = (cfg.image_height < 12'd3) ? 12'd3 : cfg.image_height;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        drain_next = drain_reg;
        emit_next  = emit_reg;
        slot_next  = slot_reg;
        addr_next  = addr_reg;
        bit_next   = bit_reg;
        row_inc    = {1'b0, row_reg} + 13'd1;
        row_t      = {1'b0, row_reg};
        col_inc    = col_reg + NW'(1);
        dc         = w_p1 - pend_reg;
        at_start   = (row_reg == 12'd0) && (col_reg == '0);
        p0         = at_start ? '0 : pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    drain_next = req_type;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (pend_reg > w_p1)
                begin
                    pend_next = w_p1;
                end
                if (col_reg >= w_eff)
                begin
                    col_next = '0;
                    row_t    = row_inc;
                end
                row_next   = (row_t >= {1'b0, h_eff}) ? 12'd0 : row_t[11:0];
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                slot_next.clamp_top = 1'b0;
                slot_next.clamp_bot = 1'b0;
                slot_next.frame_end = 1'b0;
                if (drain_reg)
                begin
                    if (!at_start || (pend_reg == '0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next          = 1'b1;
                        pend_next          = pend_reg - NW'(1);
                        slot_next.col_zero = (pend_reg == NW'(1)) || (dc == '0);
                        slot_next.col_one  = (pend_reg != NW'(1)) && (dc == NW'(1));
                        slot_next.clamp_bot = (pend_reg != w_p1);
                        slot_next.frame_end = (pend_reg == NW'(1));
                        addr_next  = (pend_reg == NW'(1)) ? '0 : dc[AW-1:0];
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    emit_next          = (p0 == w_p1);
                    pend_next          = (p0 == w_p1) ? p0 : p0 + NW'(1);
                    slot_next.col_zero = (col_reg == '0);
                    slot_next.col_one  = (col_reg == NW'(1));
                    slot_next.clamp_top = (col_reg == '0) ? (row_reg <= 12'd2)
                                                          : (row_reg <= 12'd1);
                    addr_next = col_reg[AW-1:0];
                    if (col_inc >= w_eff)
                    begin
                        col_next = '0;
                        row_next = (row_inc >= {1'b0, h_eff}) ? 12'd0 : row_inc[11:0];
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = emit_reg ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                bit_next   = 3'd7;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            drain_reg <= 1'b0;
            emit_reg  <= 1'b0;
            slot_reg  <= '0;
            addr_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            drain_reg <= drain_next;
            emit_reg  <= emit_next;
            slot_reg  <= slot_next;
            addr_reg  <= addr_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        req_stall       = (state_reg != ST_IDLE);
        cmd.load_item   = (state_reg == ST_IDLE) && req_valid;
        cmd.mem_read    = (state_reg == ST_READ);
        cmd.slot_load   = (state_reg == ST_LOAD);
        cmd.mul1        = (state_reg == ST_MUL1);
        cmd.mul2        = (state_reg == ST_MUL2);
        cmd.square      = (state_reg == ST_SQUARE);
        cmd.search_step = (state_reg == ST_SEARCH);
        cmd.out_load    = (state_reg == ST_EMIT) && !stat.out_busy;
        cmd.bit_idx     = bit_reg;
        cmd.slot        = slot_reg;
        addr            = addr_reg;
    end

    `ESF_ASSERT_IMPL(a_pend_bound, 1'b1, pend_reg <= NW'(MAX_WIDTH + 1))
    `ESF_ASSERT_NEXT(a_accept_norm, req_valid && !req_stall, state_reg == ST_NORM)
    `ESF_ASSERT_NEXT(a_search_done, state_reg == ST_SEARCH && bit_reg == 3'd0, state_reg == ST_EMIT)
    `ESF_ASSERT_IMPL(a_col_in_line, state_reg == ST_READ, col_reg < w_eff)

endmodule

// ===== sv/emboss_shading_filter.sv =====
`timescale 1ns / 1ps
// An item that yields a shade passes NORM, DECODE, READ, LOAD, MUL1, MUL2, SQUARE, the
// 8-step quotient search loop and EMIT, which waits out a stalled output; a pixel with
// no result leaves after LOAD, an ignored drain after DECODE; only IDLE accepts items.
// Reset: rst_n clears counters, window and control; line stores hold no reset value,
// configuration returns to its documented defaults.
module emboss_shading_filter #(
    parameter int MAX_WIDTH = esf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  esf_pkg::req_t               req_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output esf_pkg::res_t               res_data,
    input  logic                        cfg_we,
    input  logic [esf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [esf_pkg::CFG_DW-1:0]  cfg_data
);

    esf_pkg::cfg_t   cfg_reg;
    esf_pkg::cmd_t   cmd;
    esf_pkg::stat_t  stat;
    logic [$clog2(MAX_WIDTH)-1:0] addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 12'd640;
            cfg_reg.image_height <= 12'd480;
            cfg_reg.color_mode   <= 1'b0;
            cfg_reg.light_x      <= '0;
            cfg_reg.light_y      <= '0;
            cfg_reg.light_dot_z  <= '0;
            cfg_reg.normal_z_sq  <= '0;
            cfg_reg.background   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (esf_pkg::reg_idx_t'(cfg_index))
                esf_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[11:0];
                esf_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[11:0];
                esf_pkg::REG_COLOR_MODE:   cfg_reg.color_mode   <= cfg_data[0];
                esf_pkg::REG_LIGHT_X:      cfg_reg.light_x      <= cfg_data[16:0];
                esf_pkg::REG_LIGHT_Y:      cfg_reg.light_y      <= cfg_data[16:0];
                esf_pkg::REG_LIGHT_DOT_Z:  cfg_reg.light_dot_z  <= cfg_data[27:0];
                esf_pkg::REG_NORMAL_Z_SQ:  cfg_reg.normal_z_sq  <= cfg_data[21:0];
                esf_pkg::REG_BACKGROUND:   cfg_reg.background   <= cfg_data[8:0];
                default:                   cfg_reg.background   <= cfg_reg.background;
            endcase
        end
    end

    esf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_stall (req_stall),
        .cmd       (cmd),
        .addr      (addr),
        .stat      (stat)
    );

    esf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_data  (req_data),
        .cmd       (cmd),
        .addr      (addr),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== dv/tb_emboss_shading_filter.sv =====
`timescale 1ns / 1ps
module tb_emboss_shading_filter;

    localparam int MAXW = 2048;
    localparam int LONG_HOLD = 600;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    esf_pkg::req_t req_data;
    logic res_valid;
    logic res_stall;
    esf_pkg::res_t res_data;
    logic cfg_we;
    logic [esf_pkg::CFG_IW-1:0] cfg_index;
    logic [esf_pkg::CFG_DW-1:0] cfg_data;

    emboss_shading_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shading model state
    esf_pkg::cfg_t shd_cfg;
    logic [9:0]  upper_line [MAXW];
    logic [9:0]  middle_line [MAXW];
    logic [9:0]  win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned backlog;

    esf_pkg::req_t pixel_queue [$];
    esf_pkg::res_t shade_queue [$];
    int   errors;
    int   idle_pct;
    int   stall_pct;
    int   phase_num;
    bit   long_hold_phase;
    bit   req_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("** emboss_shading_filter: FAILED **");
        $finish;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = shd_cfg.image_width;
        if (w < 3) w = 3;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (shd_cfg.image_height < 3) ? 3 : shd_cfg.image_height;
    endfunction

    function automatic logic [7:0] lambert_shade(int cm0, int cm1, int cm2, bit ct, bit cb);
        longint g [3][3];
        longint dx;
        longint dy;
        longint dot;
        longint b;
        longint unsigned dot2;
        longint unsigned s;
        longint unsigned t;
        int cmv [3];
        int rr;
        logic [7:0] q;
        cmv[0] = cm0;
        cmv[1] = cm1;
        cmv[2] = cm2;
        for (int r = 0; r < 3; r++)
        begin
            rr = r;
            if (r == 0 && ct) rr = 1;
            if (r == 2 && cb) rr = 1;
            for (int c = 0; c < 3; c++)
                g[r][c] = win[rr * 3 + cmv[c]];
        end
        dx = 0;
        dy = 0;
        for (int r = 0; r < 3; r++) dx += g[r][0] - g[r][2];
        for (int c = 0; c < 3; c++) dy += g[2][c] - g[0][c];
        if (dx == 0 && dy == 0)
        begin
            b = shd_cfg.background;
            if (b < 0) b = 0;
            if (b > 255) b = 255;
            return b[7:0];
        end
        dot = dx * longint'(shd_cfg.light_x) + dy * longint'(shd_cfg.light_y)
            + longint'(shd_cfg.light_dot_z);
        if (dot < 0) return 8'd0;
        dot2 = dot * dot;
        s = dx * dx + dy * dy + shd_cfg.normal_z_sq;
        q = 8'd0;
        for (int bt = 7; bt >= 0; bt--)
        begin
            t = longint'(q | (8'd1 << bt)) * 256;
            if (t * t * s <= dot2) q[bt] = 1'b1;
        end
        return q;
    endfunction

    task automatic pixel_slot(int unsigned r, int unsigned c, logic [9:0] v, bit emit);
        logic [9:0] top;
        logic [9:0] mid;
        logic [7:0] sh;
        int rc;
        int cc;
        int w;
        int h;
        esf_pkg::res_t exp_res;
        w = eff_width();
        h = eff_height();
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = v;
        if (c == 0)
        begin
            rc = int'(r) - 2;
            cc = w - 1;
            sh = lambert_shade(1, 2, 2, rc <= 0, rc >= h - 1);
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = v;
        if (c != 0)
        begin
            rc = int'(r) - 1;
            cc = int'(c) - 1;
            sh = lambert_shade((c == 1) ? 1 : 0, 1, 2, rc <= 0, rc >= h - 1);
        end
        if (emit)
        begin
            exp_res.shade = sh;
            exp_res.frame_end = (rc == h - 1 && cc == w - 1);
            shade_queue.push_back(exp_res);
        end
    endtask

    task automatic predict_transaction(esf_pkg::req_t r);
        int unsigned w;
        int unsigned h;
        int unsigned dc;
        logic [9:0] v;
        bit emit;
        w = eff_width();
        h = eff_height();
        if (backlog > w + 1) backlog = w + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        if (r.req_type)
        begin
            if (row_pos != 0 || col_pos != 0 || backlog == 0) return;
            dc = w + 1 - backlog;
            if (dc >= w) pixel_slot(h + 1, 0, 10'd0, 1'b1);
            else pixel_slot(h, dc, 10'd0, 1'b1);
            backlog--;
            return;
        end
        v = r.chan0;
        if (shd_cfg.color_mode) v = v + r.chan1 + r.chan2;
        if (row_pos == 0 && col_pos == 0) backlog = 0;
        emit = backlog >= w + 1;
        if (!emit) backlog++;
        pixel_slot(row_pos, col_pos, v, emit);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
        end
        else if (req_taken || !req_valid)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req_valid <= 1'b1;
                req_data <= pixel_queue.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    int hold_cnt;
    int hold_phase;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_cnt = 0;
            hold_phase = -1;
        end
        else
        begin
            if (long_hold_phase && hold_phase != phase_num)
            begin
                hold_phase = phase_num;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n && req_valid && !req_stall)
        begin
            req_taken = 1'b1;
            predict_transaction(req_data);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            if (shade_queue.size() == 0)
            begin
                $error("unexpected transaction shade=%0d frame_end=%0d",
                       res_data.shade, res_data.frame_end);
                errors++;
            end
            else
            begin
                esf_pkg::res_t e;
                e = shade_queue.pop_front();
                if (res_data.shade !== e.shade)
                begin
                    $error("shade expected %0d actual %0d", e.shade, res_data.shade);
                    errors++;
                end
                if (res_data.frame_end !== e.frame_end)
                begin
                    $error("frame_end expected %0d actual %0d", e.frame_end,
                           res_data.frame_end);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(esf_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= esf_pkg::CFG_DW'(value);
        case (idx)
            esf_pkg::REG_IMAGE_WIDTH:  shd_cfg.image_width = 12'(value);
            esf_pkg::REG_IMAGE_HEIGHT: shd_cfg.image_height = 12'(value);
            esf_pkg::REG_COLOR_MODE:   shd_cfg.color_mode = value[0];
            esf_pkg::REG_LIGHT_X:      shd_cfg.light_x = 17'(value);
            esf_pkg::REG_LIGHT_Y:      shd_cfg.light_y = 17'(value);
            esf_pkg::REG_LIGHT_DOT_Z:  shd_cfg.light_dot_z = 28'(value);
            esf_pkg::REG_NORMAL_Z_SQ:  shd_cfg.normal_z_sq = 22'(value);
            esf_pkg::REG_BACKGROUND:   shd_cfg.background = 9'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || req_valid || shade_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic esf_pkg::req_t make_pixel(int style);
        esf_pkg::req_t r;
        r.req_type = 1'b0;
        r.chan0 = 8'($urandom_range(255));
        r.chan1 = 8'($urandom_range(255));
        r.chan2 = 8'($urandom_range(255));
        if (style == 1)
        begin
            r.chan0 = 8'd77;
            r.chan1 = 8'd9;
            r.chan2 = 8'd200;
        end
        else if (style == 2)
        begin
            r.chan0 = $urandom_range(1) ? 8'd255 : 8'd0;
            r.chan1 = $urandom_range(1) ? 8'd255 : 8'd0;
            r.chan2 = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        return r;
    endfunction

    function automatic esf_pkg::req_t make_drain();
        esf_pkg::req_t r;
        r = make_pixel(0);
        r.req_type = 1'b1;
        return r;
    endfunction

    // push one frame plus drains; random stray drains mid-frame
    task automatic push_frame(int unsigned w, int unsigned h, int style, int drains);
        for (int unsigned i = 0; i < w * h; i++)
        begin
            pixel_queue.push_back(make_pixel(style));
            if ($urandom_range(19) == 0) pixel_queue.push_back(make_drain());
        end
        for (int i = 0; i < drains; i++) pixel_queue.push_back(make_drain());
    endtask

    task automatic set_light();
        int sel;
        sel = $urandom_range(3);
        write_reg(esf_pkg::REG_LIGHT_X,
                  sel == 0 ? 65280 : (sel == 1 ? -65280 : $urandom_range(130560) - 65280));
        sel = $urandom_range(3);
        write_reg(esf_pkg::REG_LIGHT_Y,
                  sel == 0 ? -65280 : (sel == 1 ? 65280 : $urandom_range(130560) - 65280));
        sel = $urandom_range(4);
        write_reg(esf_pkg::REG_LIGHT_DOT_Z, sel == 0 ? 134217727 : (sel == 1 ? -134217728 :
                  $urandom_range(4000000) - 500000));
        sel = $urandom_range(3);
        write_reg(esf_pkg::REG_NORMAL_Z_SQ,
                  sel == 0 ? 0 : (sel == 1 ? 4194303 : $urandom_range(20000)));
        write_reg(esf_pkg::REG_BACKGROUND, $urandom_range(510) - 255);
        write_reg(esf_pkg::REG_COLOR_MODE, $urandom_range(1));
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int sent;
        int drains;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        phase_num = 0;
        long_hold_phase = 1'b0;
        req_taken = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        shd_cfg = '0;
        shd_cfg.image_width = 12'd640;
        shd_cfg.image_height = 12'd480;
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (middle_line[i]) middle_line[i] = '0;
        foreach (win[i]) win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        backlog = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: flat frame, background extremes, drain on empty
        pixel_queue.push_back(make_drain());
        wait_idle();
        write_reg(esf_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(esf_pkg::REG_IMAGE_HEIGHT, 0);
        write_reg(esf_pkg::REG_BACKGROUND, 255);
        push_frame(3, 3, 1, 5);
        wait_idle();
        write_reg(esf_pkg::REG_BACKGROUND, -255);
        write_reg(esf_pkg::REG_COLOR_MODE, 1);
        write_reg(esf_pkg::REG_LIGHT_X, 65280);
        write_reg(esf_pkg::REG_LIGHT_Y, -65280);
        write_reg(esf_pkg::REG_LIGHT_DOT_Z, 134217727);
        write_reg(esf_pkg::REG_NORMAL_Z_SQ, 0);
        push_frame(3, 3, 2, 4);
        wait_idle();

        // partial frame at the tallest height, then end it by lowering the height
        write_reg(esf_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(esf_pkg::REG_IMAGE_HEIGHT, 4095);
        push_frame(3, 6, 0, 0);
        wait_idle();
        write_reg(esf_pkg::REG_IMAGE_HEIGHT, 3);
        push_frame(3, 3, 0, 4);
        wait_idle();

        sent = 0;
        while (sent < 650)
        begin
            phase_num++;
            idle_pct  = (phase_num % 4 == 1) ? 47 : ((phase_num % 4 == 3) ? 9 : 0);
            stall_pct = (phase_num % 4 == 2) ? 47 : ((phase_num % 4 == 3) ? 9 : 0);
            long_hold_phase = (phase_num == 5);
            set_light();
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 6);
            write_reg(esf_pkg::REG_IMAGE_WIDTH, w);
            write_reg(esf_pkg::REG_IMAGE_HEIGHT, h);
            for (int f = 0; f < 2; f++)
            begin
                case ($urandom_range(5))
                    0: drains = 0;
                    1: drains = $urandom_range(w);
                    2: drains = w + 1 + $urandom_range(3);
                    default: drains = w + 1;
                endcase
                if (f == 1 && drains < w + 1) drains = w + 1;
                push_frame(w, h, ($urandom_range(7) == 0) ? 1 : ($urandom_range(3) == 0 ? 2 : 0),
                           drains);
                sent += w * h + drains;
                if (phase_num % 3 == 0) wait_idle();
            end
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("** emboss_shading_filter: PASSED **");
        end
        else
        begin
            $display("** emboss_shading_filter: FAILED **");
        end
        $finish;
    end

endmodule
